FILE: rtl/ccp_pkg.sv
// ----------------------------------------------------------------------------
// ccp_pkg: calendar clock prescaler shared definitions
// Types, calendar constants and date helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package ccp_pkg;

    localparam int unsigned MIN_PER_HOUR = 60;
    localparam int unsigned HOUR_PER_DAY = 24;
    localparam int unsigned MONTH_COUNT  = 12;

    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [13:0] YEAR_RESET = 14'd2000;
    localparam logic [31:0] MIN_LEN_RESET = 32'd65536;

    // request codes
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_MIN_LEN   = 3'd0;
    localparam logic [2:0] REG_START_DAY = 3'd1;
    localparam logic [2:0] REG_START_MON = 3'd2;
    localparam logic [2:0] REG_START_YR  = 3'd3;
    localparam logic [2:0] REG_CYCLE_EN  = 3'd4;

    localparam logic [8:0] DAYS_BEFORE [MONTH_COUNT] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };
    localparam logic [4:0] MONTH_DAYS [MONTH_COUNT] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [31:0] minute_length;
        logic [4:0]  start_day;
        logic [3:0]  start_month;
        logic [13:0] start_year;
        logic        cycle_enable;
    } t_cfg;

    typedef struct packed {
        logic signed [33:0] remainder;
        logic [5:0]         minute;
        logic [4:0]         hour;
        logic [4:0]         day;
        logic [3:0]         month;
        logic [13:0]        year;
        logic [8:0]         day_of_year;
    } t_state;

    // y / 100 by reciprocal, exact for any 14-bit year
    function automatic logic f_is_leap(input logic [13:0] y);
        logic [26:0] prod;
        logic [7:0]  q;
        logic [13:0] r;
        prod = 27'(y) * 27'(13'd5243);
        q    = prod[26:19];
        r    = y - 14'(15'(q) * 15'd100);
        return ((y[1:0] == 2'd0) && (r != 14'd0)) ||
               ((r == 14'd0) && (q[1:0] == 2'd0));
    endfunction

    function automatic logic [3:0] f_month_idx(input logic [3:0] m);
        return ((m >= 4'd1) && (m <= 4'(MONTH_COUNT))) ? (m - 4'd1) : 4'd0;
    endfunction

    function automatic logic [4:0] f_days_in(input logic [13:0] y, input logic [3:0] m);
        logic [3:0] i;
        logic [4:0] d;
        i = f_month_idx(m);
        d = MONTH_DAYS[i];
        if ((i == 4'd1) && f_is_leap(y)) begin
            d = 5'd29;
        end
        return d;
    endfunction

    function automatic logic [8:0] f_day_of_year(input logic [13:0] y, input logic [3:0] m,
                                                 input logic [4:0] d);
        logic [3:0] i;
        logic [8:0] n;
        i = f_month_idx(m);
        n = DAYS_BEFORE[i] + 9'(d);
        if ((i >= 4'd2) && f_is_leap(y)) begin
            n = n + 9'd1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ccp_if.sv
// ----------------------------------------------------------------------------
// ccp_if: calendar clock prescaler channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccp_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [23:0] elapsed;

    modport source (output valid, output req_type, output elapsed, input ready);
    modport sink   (input valid, input req_type, input elapsed, output ready);
endinterface

interface ccp_res_if;
    logic        valid;
    logic        ready;
    logic [5:0]  minute_out;
    logic [4:0]  hour_out;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [13:0] year_out;
    logic [8:0]  day_of_year_out;
    logic [10:0] minute_of_day;
    logic        time_changed;

    modport source (output valid, output minute_out, output hour_out, output day_out,
                    output month_out, output year_out, output day_of_year_out,
                    output minute_of_day, output time_changed, input ready);
    modport sink   (input valid, input minute_out, input hour_out, input day_out,
                    input month_out, input year_out, input day_of_year_out,
                    input minute_of_day, input time_changed, output ready);
endinterface

`default_nettype wire

FILE: rtl/ccp_step.sv
// ----------------------------------------------------------------------------
// ccp_step: next-state logic for one item
// Remainder update, one-minute advance with calendar carry, date load.
// ----------------------------------------------------------------------------
`default_nettype none

module ccp_step (
    input  ccp_pkg::t_cfg   i_cfg,
    input  ccp_pkg::t_state i_state,
    input  logic            i_req_type,
    input  logic [23:0]     i_elapsed,
    output ccp_pkg::t_state o_state,
    output logic [10:0]     o_minute_of_day,
    output logic            o_changed
);
    import ccp_pkg::*;

    logic signed [34:0] rem_sub;
    logic signed [34:0] rem_add;
    logic               rem_sat;
    logic               adv;
    logic               last_day;
    logic [3:0]         ld_month;
    logic [13:0]        ld_year;
    logic [4:0]         ld_dim;
    logic [4:0]         ld_day;
    t_state             nxt;

    assign rem_sub = 35'(i_state.remainder) - $signed({11'd0, i_elapsed});
    assign adv     = (rem_sub <= 35'sd0);
    assign rem_add = adv ? (rem_sub + $signed({3'd0, i_cfg.minute_length})) : rem_sub;
    assign rem_sat = rem_add[34] & ~rem_add[33];

    assign last_day = (i_state.day >= f_days_in(i_state.year, i_state.month));

    always_comb begin
        ld_month = i_cfg.start_month;
        if (ld_month < 4'd1) begin
            ld_month = 4'd1;
        end else if (ld_month > 4'(MONTH_COUNT)) begin
            ld_month = 4'(MONTH_COUNT);
        end
        ld_year = i_cfg.start_year;
        if (ld_year < 14'd1) begin
            ld_year = 14'd1;
        end else if (ld_year > YEAR_MAX) begin
            ld_year = YEAR_MAX;
        end
        ld_dim = f_days_in(ld_year, ld_month);
        ld_day = i_cfg.start_day;
        if (ld_day < 5'd1) begin
            ld_day = 5'd1;
        end else if (ld_day > ld_dim) begin
            ld_day = ld_dim;
        end
    end

    always_comb begin
        nxt       = i_state;
        o_changed = 1'b0;
        if (i_req_type == REQ_LOAD) begin
            nxt.day         = ld_day;
            nxt.month       = ld_month;
            nxt.year        = ld_year;
            nxt.day_of_year = f_day_of_year(ld_year, ld_month, ld_day);
            nxt.remainder   = $signed({2'd0, i_cfg.minute_length});
            o_changed       = 1'b1;
        end else if (i_cfg.cycle_enable) begin
            nxt.remainder = rem_sat ? {1'b1, 33'd0} : rem_add[33:0];
            if (adv) begin
                o_changed = 1'b1;
                if (i_state.minute != 6'(MIN_PER_HOUR - 1)) begin
                    nxt.minute = i_state.minute + 6'd1;
                end else begin
                    nxt.minute = 6'd0;
                    if (i_state.hour != 5'(HOUR_PER_DAY - 1)) begin
                        nxt.hour = i_state.hour + 5'd1;
                    end else begin
                        nxt.hour = 5'd0;
                        if (!last_day) begin
                            nxt.day = i_state.day + 5'd1;
                        end else begin
                            nxt.day = 5'd1;
                            if (i_state.month < 4'(MONTH_COUNT)) begin
                                nxt.month = i_state.month + 4'd1;
                            end else begin
                                nxt.month = 4'd1;
                                if (i_state.year < YEAR_MAX) begin
                                    nxt.year = i_state.year + 14'd1;
                                end
                            end
                        end
                        nxt.day_of_year = f_day_of_year(nxt.year, nxt.month, nxt.day);
                    end
                end
            end
        end
    end

    assign o_state         = nxt;
    assign o_minute_of_day = {nxt.hour, 6'd0} - {4'd0, nxt.hour, 2'd0} + {5'd0, nxt.minute};

endmodule

`default_nettype wire

FILE: rtl/calendar_clock_prescaler.sv
// ----------------------------------------------------------------------------
// calendar_clock_prescaler: minute clock with Gregorian calendar
// Ticks count down a remainder and advance one minute per expiry (if enabled);
// loads set the date from configuration. One result item per request item.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  i_req     in   valid/ready   req_type, elapsed
//  o_res     out  valid/ready   date, time, day of year, minute of day, changed
//  i_cfg_*   in   write enable  register index, 32-bit data
//
//  One item per cycle while results are taken; acceptance loads the result
//  into the output register. The state update and the result register share
//  one edge. Reset is synchronous: date 2000-01-01 00:00, remainder zero.
//  A stalled result blocks input only when it is not taken in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_clock_prescaler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ccp_req_if.sink     i_req,
    ccp_res_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import ccp_pkg::*;

    t_cfg        r_cfg;
    t_state      r_state;
    t_state      n_state;
    logic [10:0] n_minute_of_day;
    logic        n_changed;
    logic        r_out_valid;
    logic [10:0] r_minute_of_day;
    logic        r_changed;
    logic        accept;

    assign i_req.ready = ~r_out_valid | o_res.ready;
    assign accept      = i_req.valid & i_req.ready;

    ccp_step u_step (
        .i_cfg           (r_cfg),
        .i_state         (r_state),
        .i_req_type      (i_req.req_type),
        .i_elapsed       (i_req.elapsed),
        .o_state         (n_state),
        .o_minute_of_day (n_minute_of_day),
        .o_changed       (n_changed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.minute_length <= MIN_LEN_RESET;
            r_cfg.start_day     <= 5'd1;
            r_cfg.start_month   <= 4'd1;
            r_cfg.start_year    <= YEAR_RESET;
            r_cfg.cycle_enable  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MIN_LEN:   r_cfg.minute_length <= i_cfg_data;
                REG_START_DAY: r_cfg.start_day     <= i_cfg_data[4:0];
                REG_START_MON: r_cfg.start_month   <= i_cfg_data[3:0];
                REG_START_YR:  r_cfg.start_year    <= i_cfg_data[13:0];
                REG_CYCLE_EN:  r_cfg.cycle_enable  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.remainder   <= 34'sd0;
            r_state.minute      <= 6'd0;
            r_state.hour        <= 5'd0;
            r_state.day         <= 5'd1;
            r_state.month       <= 4'd1;
            r_state.year        <= YEAR_RESET;
            r_state.day_of_year <= 9'd1;
            r_out_valid         <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_minute_of_day <= n_minute_of_day;
            r_changed       <= n_changed;
        end
    end

    // date fields of the result equal the updated state
    assign o_res.valid           = r_out_valid;
    assign o_res.minute_out      = r_state.minute;
    assign o_res.hour_out        = r_state.hour;
    assign o_res.day_out         = r_state.day;
    assign o_res.month_out       = r_state.month;
    assign o_res.year_out        = r_state.year;
    assign o_res.day_of_year_out = r_state.day_of_year;
    assign o_res.minute_of_day   = r_minute_of_day;
    assign o_res.time_changed    = r_changed;

endmodule

`default_nettype wire

FILE: sim/tb_calendar_clock_prescaler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_calendar_clock_prescaler: self-checking bench for the minute clock
// Drives tick and load items over valid/ready with random gaps and stalls,
// predicts the date, time and changed flag of every item with a shadow
// calendar, and compares each result item field by field in order.
// ----------------------------------------------------------------------------
module tb_calendar_clock_prescaler;
    import ccp_pkg::*;

    localparam longint      REM_FLOOR      = -(longint'(1) << 33);
    localparam logic [23:0] ELAPSED_MAX    = 24'hFF_FFFF;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          PHASE_LEN      = 620;
    localparam int unsigned LAST_MINUTE    = MIN_PER_HOUR * HOUR_PER_DAY - 1;
    localparam int unsigned WALK_LEN_MAX   = 65536;

    typedef struct {
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [8:0]  doy;
        logic [10:0] mod;
        logic        changed;
    } cal_reading_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    ccp_req_if req_if ();
    ccp_res_if res_if ();

    calendar_clock_prescaler i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow calendar and registers
    int unsigned cal_min, cal_hour, cal_day, cal_month, cal_year, cal_doy;
    longint      rem_units;
    logic [31:0] min_len_cfg;
    int unsigned start_day_cfg, start_month_cfg, start_year_cfg;
    bit          run_cfg;

    cal_reading_t pending_readings[$];

    int fail_cnt, items_sent, loads_seen, minutes_advanced, floor_hits, cfg_writes;
    int snd_idle_pct, rcv_idle_pct, hold_cycles, quiet_cycles;
    bit no_gap;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_len(input int unsigned y, input int unsigned m);
        case (m)
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic int unsigned year_day(input int unsigned y, input int unsigned m,
                                             input int unsigned d);
        int unsigned n;
        n = d;
        for (int unsigned k = 1; k < m; k++) begin
            n += month_len(y, k);
        end
        return n;
    endfunction

    function automatic cal_reading_t calendar_step(input logic kind, input logic [23:0] el);
        cal_reading_t r;
        longint       acc;
        int unsigned  m, y, d;
        bit           changed;
        changed = 1'b0;
        if (kind == REQ_LOAD) begin
            m = start_month_cfg;
            y = start_year_cfg;
            d = start_day_cfg;
            if (m < 1) m = 1;
            if (m > MONTH_COUNT) m = MONTH_COUNT;
            if (y < 1) y = 1;
            if (y > YEAR_MAX) y = YEAR_MAX;
            if (d < 1) d = 1;
            if (d > month_len(y, m)) d = month_len(y, m);
            cal_day   = d;
            cal_month = m;
            cal_year  = y;
            cal_doy   = year_day(y, m, d);
            rem_units = longint'(min_len_cfg);
            changed   = 1'b1;
            loads_seen++;
        end else if (run_cfg) begin
            acc = rem_units - longint'(el);
            if (acc <= 0) begin
                acc += longint'(min_len_cfg);
                changed = 1'b1;
                minutes_advanced++;
                cal_min++;
                if (cal_min == MIN_PER_HOUR) begin
                    cal_min = 0;
                    cal_hour++;
                    if (cal_hour == HOUR_PER_DAY) begin
                        cal_hour = 0;
                        cal_day++;
                        if (cal_day > month_len(cal_year, cal_month)) begin
                            cal_day = 1;
                            cal_month++;
                            if (cal_month > MONTH_COUNT) begin
                                cal_month = 1;
                                if (cal_year < YEAR_MAX) cal_year++;
                            end
                        end
                        cal_doy = year_day(cal_year, cal_month, cal_day);
                    end
                end
            end
            if (acc < REM_FLOOR) begin
                acc = REM_FLOOR;
                floor_hits++;
            end
            rem_units = acc;
        end
        r.minute  = 6'(cal_min);
        r.hour    = 5'(cal_hour);
        r.day     = 5'(cal_day);
        r.month   = 4'(cal_month);
        r.year    = 14'(cal_year);
        r.doy     = 9'(cal_doy);
        r.mod     = 11'(cal_hour * MIN_PER_HOUR + cal_min);
        r.changed = changed;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_cnt++;
        end
    endfunction

    function automatic logic [31:0] with_junk(input logic [31:0] val, input int w);
        return ($urandom_range(3, 0) == 0) ? (($urandom << w) | val) : val;
    endfunction

    // boundary-heavy elapsed values around the current remainder
    function automatic logic [23:0] tick_elapsed();
        longint lo;
        lo = (rem_units > 0) ? rem_units : 0;
        if (lo > ELAPSED_MAX) lo = ELAPSED_MAX;
        case ($urandom_range(4, 0))
            0:       return '0;
            1:       return ELAPSED_MAX;
            2:       return 24'(lo);
            3:       return (lo > 0) ? 24'(lo - 1) : '0;
            default: return 24'($urandom);
        endcase
    endfunction

    // mostly advancing ticks, heavy on the maximum to drive the remainder down
    function automatic logic [23:0] walk_elapsed();
        longint lo;
        int     pick;
        lo = (rem_units > 0) ? rem_units : 0;
        if (lo > ELAPSED_MAX) lo = ELAPSED_MAX;
        pick = $urandom_range(99, 0);
        if (lo > 0 && pick < 20) return 24'($urandom_range(32'(lo - 1), 0));
        pick = $urandom_range(99, 0);
        if (pick < 70) return ELAPSED_MAX;
        if (pick < 85) return 24'(lo);
        return 24'($urandom_range(32'(ELAPSED_MAX), 32'(lo)));
    endfunction

    task automatic send_item(input logic kind, input logic [23:0] el);
        int gap_pct;
        gap_pct = no_gap ? 0 : snd_idle_pct;
        while ($urandom_range(99, 0) < gap_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= kind;
        req_if.elapsed  <= el;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pending_readings.push_back(calendar_step(kind, el));
        items_sent++;
        if (items_sent == PHASE_LEN) begin
            snd_idle_pct = 85;
            rcv_idle_pct = 21;
        end else if (items_sent == 2 * PHASE_LEN) begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
        end
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_MIN_LEN:   min_len_cfg     = data;
            REG_START_DAY: start_day_cfg   = data[4:0];
            REG_START_MON: start_month_cfg = data[3:0];
            REG_START_YR:  start_year_cfg  = data[13:0];
            REG_CYCLE_EN:  run_cfg         = data[0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic load_date(input int unsigned d, input int unsigned m, input int unsigned y);
        drain_results();
        cfg_write(REG_START_DAY, d);
        cfg_write(REG_START_MON, m);
        cfg_write(REG_START_YR, y);
        send_item(REQ_LOAD, 24'($urandom));
    endtask

    task automatic random_settings(input bit keep_running);
        logic [31:0] len;
        drain_results();
        case ($urandom_range(5, 0))
            0:       len = '0;
            1:       len = 32'd1;
            2:       len = keep_running ? WALK_LEN_MAX : 32'hFFFF_FFFF;
            3:       len = keep_running ? $urandom_range(WALK_LEN_MAX, 1) : $urandom;
            default: len = $urandom_range(keep_running ? WALK_LEN_MAX : 32'h10_0000, 1);
        endcase
        cfg_write(REG_MIN_LEN, len);
        cfg_write(REG_START_DAY, with_junk($urandom_range(31, 0), 5));
        cfg_write(REG_START_MON, with_junk($urandom_range(15, 0), 4));
        cfg_write(REG_START_YR, with_junk($urandom_range(16383, 0), 14));
        cfg_write(REG_CYCLE_EN,
                  with_junk(keep_running || ($urandom_range(99, 0) < 85), 1));
        if ($urandom_range(2, 0) == 0) begin
            cfg_write(3'($urandom_range(7, REG_CYCLE_EN + 1)), $urandom);
        end
    endtask

    // remainder starts at zero, exact expiry, overshoot keeps advancing
    task automatic test_reset_and_countdown();
        send_item(REQ_TICK, '0);
        send_item(REQ_TICK, '0);
        send_item(REQ_TICK, 24'd65535);
        send_item(REQ_TICK, 24'd1);
        send_item(REQ_TICK, ELAPSED_MAX);
        send_item(REQ_TICK, '0);
        send_item(REQ_LOAD, ELAPSED_MAX);
    endtask

    task automatic test_frozen_clock();
        drain_results();
        cfg_write(REG_CYCLE_EN, '0);
        cfg_write(REG_START_DAY, 15);
        cfg_write(REG_START_MON, 6);
        cfg_write(REG_START_YR, 2024);
        send_item(REQ_TICK, ELAPSED_MAX);
        send_item(REQ_TICK, '0);
        send_item(REQ_LOAD, '0);
        send_item(REQ_TICK, ELAPSED_MAX);
        drain_results();
        cfg_write(REG_CYCLE_EN, 1);
    endtask

    task automatic test_load_clamping();
        load_date(31, 2, 2024);
        load_date(31, 2, 1900);
        load_date(31, 2, 2000);
        load_date(30, 2, 2100);
        load_date(0, 0, 0);
        load_date(31, 15, 16383);
        load_date(31, 4, 2023);
        load_date(31, 13, 2001);
    endtask

    task automatic test_zero_minute_length();
        drain_results();
        cfg_write(REG_MIN_LEN, '0);
        for (int k = REG_CYCLE_EN + 1; k < (1 << $bits(i_cfg_idx)); k++) begin
            cfg_write(3'(k), $urandom);
        end
        send_item(REQ_LOAD, '0);
        send_item(REQ_TICK, '0);
        send_item(REQ_TICK, ELAPSED_MAX);
        drain_results();
        cfg_write(REG_MIN_LEN, 32'hFFFF_FFFF);
        send_item(REQ_LOAD, '0);
        send_item(REQ_TICK, ELAPSED_MAX);
        drain_results();
        cfg_write(REG_MIN_LEN, MIN_LEN_RESET);
    endtask

    // result side holds off while items keep coming, then sender waits out the backlog
    task automatic test_backpressure();
        drain_results();
        hold_cycles = 50;
        no_gap = 1'b1;
        repeat (14) begin
            if ($urandom_range(3, 0) == 0) send_item(REQ_LOAD, 24'($urandom));
            else send_item(REQ_TICK, tick_elapsed());
        end
        no_gap = 1'b0;
        drain_results();
    endtask

    // run the clock to 23:59, then cross midnight on the last day of year 9999
    task automatic test_calendar_walk();
        int n;
        random_settings(1'b1);
        n = 0;
        while (cal_hour * MIN_PER_HOUR + cal_min != LAST_MINUTE) begin
            if (n % 250 == 249) random_settings(1'b1);
            if (n > 900 && $urandom_range(99, 0) < 3) send_item(REQ_LOAD, 24'($urandom));
            else send_item(REQ_TICK, walk_elapsed());
            n++;
        end
        drain_results();
        cfg_write(REG_MIN_LEN, $urandom_range(WALK_LEN_MAX, 1));
        load_date(31, MONTH_COUNT, YEAR_MAX);
        send_item(REQ_TICK, ELAPSED_MAX);
        send_item(REQ_TICK, walk_elapsed());
        send_item(REQ_TICK, walk_elapsed());
    endtask

    task automatic test_random_mix();
        repeat (10) begin
            random_settings(1'b0);
            repeat (40) begin
                if ($urandom_range(99, 0) < 20) send_item(REQ_LOAD, 24'($urandom));
                else send_item(REQ_TICK, tick_elapsed());
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        cal_reading_t want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_readings.size() == 0) begin
                $error("result item with no request outstanding");
                fail_cnt++;
            end else begin
                want = pending_readings.pop_front();
                check_field("minute_out", want.minute, res_if.minute_out);
                check_field("hour_out", want.hour, res_if.hour_out);
                check_field("day_out", want.day, res_if.day_out);
                check_field("month_out", want.month, res_if.month_out);
                check_field("year_out", want.year, res_if.year_out);
                check_field("day_of_year_out", want.doy, res_if.day_of_year_out);
                check_field("minute_of_day", want.mod, res_if.minute_of_day);
                check_field("time_changed", want.changed, res_if.time_changed);
            end
        end
    end

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                res_if.ready <= 1'b0;
                hold_cycles--;
            end else begin
                res_if.ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("watchdog: %0d cycles without a handshake", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_TICK;
        req_if.elapsed  = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_MIN_LEN;
        i_cfg_data      = '0;
        min_len_cfg     = MIN_LEN_RESET;
        start_day_cfg   = 1;
        start_month_cfg = 1;
        start_year_cfg  = YEAR_RESET;
        run_cfg         = 1'b1;
        rem_units       = 0;
        cal_min         = 0;
        cal_hour        = 0;
        cal_day         = 1;
        cal_month       = 1;
        cal_year        = YEAR_RESET;
        cal_doy         = 1;
        snd_idle_pct    = 21;
        rcv_idle_pct    = 85;
        hold_cycles     = 0;
        no_gap          = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_and_countdown();
        test_frozen_clock();
        test_load_clamping();
        test_zero_minute_length();
        test_backpressure();
        test_calendar_walk();
        test_random_mix();

        drain_results();
        repeat (4) @(posedge i_clk);
        $display("Sent %0d items (%0d loads) through %0d register writes;", items_sent,
                 loads_seen, cfg_writes);
        $display("clock advanced %0d minutes, remainder hit its floor %0d times.",
                 minutes_advanced, floor_hits);
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: calendar_clock_prescaler.f
rtl/ccp_pkg.sv
rtl/ccp_if.sv
rtl/ccp_step.sv
rtl/calendar_clock_prescaler.sv
sim/tb_calendar_clock_prescaler.sv
